// ----- design/kpsr_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsr_pkg: shared types and constants for the keypad and serial register block
// Transfer structs, command word passed from front to back, register map.
// ----------------------------------------------------------------------------
package kpsr_pkg;

    // item actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_KEY   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // access sizes (size 3 acts as a word)
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam int unsigned QUEUE_DEPTH = 2;

    // stored halfwords: only those that can ever be read back
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned KEY_IDX  = 2;   // key input, halfword 8
    localparam int unsigned CTRL_IDX = 3;   // key control, halfword 9
    localparam int unsigned RCNT_IDX = 4;   // halfword 10

    localparam logic [6:0] REG_HW [NUM_REGS] = '{
        7'd4, 7'd5, 7'd8, 7'd9, 7'd10, 7'd16, 7'd26, 7'd27
    };

    localparam logic [15:0] KEY_RESET  = 16'h03FF;
    localparam logic [15:0] RCNT_RESET = 16'h8000;

    localparam int unsigned KEY_BITS     = 10;
    localparam int unsigned KEY_MAX      = 9;
    localparam int unsigned IRQ_EN_BIT   = 14;
    localparam int unsigned IRQ_AND_BIT  = 15;

    // read rows: pairs of halfwords that form one aligned word
    localparam logic [2:0] ROW_0809 = 3'd0;  // 0x08 / 0x0A
    localparam logic [2:0] ROW_1013 = 3'd1;  // 0x10 / 0x12
    localparam logic [2:0] ROW_14   = 3'd2;  // 0x14, high half reads 0
    localparam logic [2:0] ROW_20   = 3'd3;  // 0x20, high half reads 0
    localparam logic [2:0] ROW_3437 = 3'd4;  // 0x34 / 0x36

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [3:0]  key_number;
        logic        key_down;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        read_hit;
        logic        key_irq;
    } rsp_t;

    typedef struct packed {
        logic       hit;
        logic       is_reg;
        logic [2:0] row;
    } rd_class_t;

    typedef struct packed {
        logic [1:0]                     action;
        // read side
        logic                           rd_hit;
        logic                           rd_reg;
        logic [2:0]                     rd_row;
        logic [1:0]                     rd_size;
        logic                           rd_half;
        logic                           rd_byte_hi;
        // write side
        logic [NUM_REGS-1:0][1:0]       wr_be;
        logic [31:0]                    wr_lane;
        // key side
        logic [KEY_BITS-1:0]            key_mask;
        logic                           key_down;
    } cmd_t;

    // class of one halfword offset for reads
    function automatic rd_class_t classify_half(input logic [6:0] hw);
        rd_class_t c;
        c = '{hit: 1'b0, is_reg: 1'b0, row: ROW_0809};
        case (hw)
            7'd0, 7'd1, 7'd2, 7'd3, 7'd11, 7'd24, 7'd25, 7'd28: c.hit = 1'b1;
            7'd4, 7'd5:   c = '{hit: 1'b1, is_reg: 1'b1, row: ROW_0809};
            7'd8, 7'd9:   c = '{hit: 1'b1, is_reg: 1'b1, row: ROW_1013};
            7'd10:        c = '{hit: 1'b1, is_reg: 1'b1, row: ROW_14};
            7'd16:        c = '{hit: 1'b1, is_reg: 1'b1, row: ROW_20};
            7'd26, 7'd27: c = '{hit: 1'b1, is_reg: 1'b1, row: ROW_3437};
            default:      c.hit = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ----- design/kpsr_front.sv -----
// ----------------------------------------------------------------------------
// kpsr_front: request intake and decode
// Classifies each request and turns it into a command for the back end.
// ----------------------------------------------------------------------------
module kpsr_front (
    input  logic            req_valid,
    output logic            req_stall,
    input  kpsr_pkg::req_t  req,
    input  logic            queue_full,
    output logic            push,
    output kpsr_pkg::cmd_t  cmd
);

    kpsr_pkg::rd_class_t rd_class;
    logic [6:0]          rd_hw;
    logic                is_word;
    logic                wr_match;
    int unsigned         i;

    assign req_stall = queue_full;
    assign push      = req_valid & ~queue_full;

    assign is_word = (req.access_size != kpsr_pkg::SIZE_BYTE) &&
                     (req.access_size != kpsr_pkg::SIZE_HALF);
    assign rd_hw    = is_word ? {req.address[7:2], 1'b0} : req.address[7:1];
    assign rd_class = kpsr_pkg::classify_half(rd_hw);

    always_comb
    begin
        cmd            = '0;
        wr_match       = 1'b0;
        cmd.action     = req.action;
        cmd.rd_hit     = rd_class.hit;
        cmd.rd_reg     = rd_class.is_reg;
        cmd.rd_row     = rd_class.row;
        cmd.rd_size    = req.access_size;
        cmd.rd_half    = req.address[1];
        cmd.rd_byte_hi = req.address[0];
        cmd.key_down   = req.key_down;

        if (req.key_number <= 4'(kpsr_pkg::KEY_MAX))
            cmd.key_mask = kpsr_pkg::KEY_BITS'(1) << req.key_number;

        // replicate narrow data so even halfwords take [15:0], odd take [31:16]
        case (req.access_size)
            kpsr_pkg::SIZE_BYTE: cmd.wr_lane = {4{req.write_data[7:0]}};
            kpsr_pkg::SIZE_HALF: cmd.wr_lane = {2{req.write_data[15:0]}};
            default:             cmd.wr_lane = req.write_data;
        endcase

        for (i = 0; i < kpsr_pkg::NUM_REGS; i++)
        begin
            if (is_word)
                wr_match = req.address[7:2] == kpsr_pkg::REG_HW[i][6:1];
            else
                wr_match = req.address[7:1] == kpsr_pkg::REG_HW[i];
            // key input is read-only from the bus
            if (req.action == kpsr_pkg::ACT_WRITE && wr_match && i != kpsr_pkg::KEY_IDX)
            begin
                if (req.access_size == kpsr_pkg::SIZE_BYTE)
                    cmd.wr_be[i] = req.address[0] ? 2'b10 : 2'b01;
                else
                    cmd.wr_be[i] = 2'b11;
            end
        end
    end

endmodule

// ----- design/kpsr_fifo.sv -----
// ----------------------------------------------------------------------------
// kpsr_fifo: command queue
// Small FIFO that decouples decode from execution.
// ----------------------------------------------------------------------------
module kpsr_fifo #(
    parameter int unsigned DEPTH = kpsr_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  kpsr_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output kpsr_pkg::cmd_t  head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    kpsr_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- design/kpsr_back.sv -----
// ----------------------------------------------------------------------------
// kpsr_back: command execution
// Holds the register bank, performs reads, writes and key updates, and
// registers the response.
// ----------------------------------------------------------------------------
module kpsr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  kpsr_pkg::cmd_t  cmd,
    output logic            pop,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output kpsr_pkg::rsp_t  rsp
);

    logic [15:0]          bank_reg  [kpsr_pkg::NUM_REGS];
    logic [15:0]          bank_next [kpsr_pkg::NUM_REGS];
    logic                 rsp_valid_reg, rsp_valid_next;
    kpsr_pkg::rsp_t       rsp_reg, rsp_next;

    logic [31:0]          row_word;
    logic [15:0]          half;
    logic [15:0]          key_cur;
    logic [15:0]          key_nxt;
    logic [15:0]          ctrl;
    logic [kpsr_pkg::KEY_BITS-1:0] pressed;
    logic [kpsr_pkg::KEY_BITS-1:0] sel;
    logic                 key_changed;
    logic                 irq;
    logic [15:0]          lane;
    int unsigned          i;

    assign pop       = cmd_valid & (~rsp_valid_reg | ~rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        case (cmd.rd_row)
            kpsr_pkg::ROW_0809: row_word = {bank_reg[1], bank_reg[0]};
            kpsr_pkg::ROW_1013: row_word = {bank_reg[3], bank_reg[2]};
            kpsr_pkg::ROW_14:   row_word = {16'h0000, bank_reg[kpsr_pkg::RCNT_IDX]};
            kpsr_pkg::ROW_20:   row_word = {16'h0000, bank_reg[5]};
            kpsr_pkg::ROW_3437: row_word = {bank_reg[7], bank_reg[6]};
            default:            row_word = '0;
        endcase
        half = cmd.rd_half ? row_word[31:16] : row_word[15:0];
    end

    // key update and interrupt check on the new key state
    always_comb
    begin
        key_cur = bank_reg[kpsr_pkg::KEY_IDX];
        key_nxt = key_cur;
        if (cmd.key_down)
            key_nxt[kpsr_pkg::KEY_BITS-1:0] = key_cur[kpsr_pkg::KEY_BITS-1:0] & ~cmd.key_mask;
        else
            key_nxt[kpsr_pkg::KEY_BITS-1:0] = key_cur[kpsr_pkg::KEY_BITS-1:0] | cmd.key_mask;
        key_changed = key_nxt != key_cur;
        ctrl    = bank_reg[kpsr_pkg::CTRL_IDX];
        pressed = ~key_nxt[kpsr_pkg::KEY_BITS-1:0];
        sel     = ctrl[kpsr_pkg::KEY_BITS-1:0];
        irq     = key_changed && ctrl[kpsr_pkg::IRQ_EN_BIT] && (|sel) && (|pressed) &&
                  (ctrl[kpsr_pkg::IRQ_AND_BIT] ? ((pressed & sel) == sel) : |(pressed & sel));
    end

    always_comb
    begin
        lane = '0;
        for (i = 0; i < kpsr_pkg::NUM_REGS; i++)
        begin
            bank_next[i] = bank_reg[i];
            lane = kpsr_pkg::REG_HW[i][0] ? cmd.wr_lane[31:16] : cmd.wr_lane[15:0];
            if (pop && cmd.action == kpsr_pkg::ACT_WRITE)
            begin
                if (cmd.wr_be[i][0])
                    bank_next[i][7:0] = lane[7:0];
                if (cmd.wr_be[i][1])
                    bank_next[i][15:8] = lane[15:8];
            end
        end
        if (pop && cmd.action == kpsr_pkg::ACT_KEY)
            bank_next[kpsr_pkg::KEY_IDX] = key_nxt;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rsp_next       = rsp_reg;
        if (pop)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            case (cmd.action)
                kpsr_pkg::ACT_READ:
                begin
                    rsp_next.read_hit = cmd.rd_hit;
                    if (cmd.rd_reg)
                    begin
                        case (cmd.rd_size)
                            kpsr_pkg::SIZE_BYTE:
                                rsp_next.read_data = {24'h0, cmd.rd_byte_hi ? half[15:8]
                                                                            : half[7:0]};
                            kpsr_pkg::SIZE_HALF:
                                rsp_next.read_data = {16'h0, half};
                            default:
                                rsp_next.read_data = row_word;
                        endcase
                    end
                end
                kpsr_pkg::ACT_WRITE:
                    rsp_next.read_hit = 1'b1;
                kpsr_pkg::ACT_KEY:
                begin
                    rsp_next.read_hit = 1'b1;
                    rsp_next.key_irq  = irq;
                end
                default:
                    rsp_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int unsigned j = 0; j < kpsr_pkg::NUM_REGS; j++)
            begin
                if (j == kpsr_pkg::KEY_IDX)
                    bank_reg[j] <= kpsr_pkg::KEY_RESET;
                else if (j == kpsr_pkg::RCNT_IDX)
                    bank_reg[j] <= kpsr_pkg::RCNT_RESET;
                else
                    bank_reg[j] <= '0;
            end
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            for (int unsigned j = 0; j < kpsr_pkg::NUM_REGS; j++)
                bank_reg[j] <= bank_next[j];
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// ----- design/keypad_serial_register_block.sv -----
// ----------------------------------------------------------------------------
// keypad_serial_register_block: keypad and serial register window
// Bus reads and writes of a 60-byte register window plus key events, with
// the keypad interrupt evaluated on each key state change.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one item per transfer:
//   a bus read, a bus write or a key event. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one result per item, in order.
//   A request is written into the decode queue, taken from its head by the
//   execution stage, and its result is captured in the response register.
//   Throughput is one item per cycle while rsp_stall is low; the execution stage reads the bank
//   and updates it in the same cycle, so an item sees every earlier write.
//   While rsp_stall is high a valid response stays in the response register and the two-entry
//   command queue fills; req_stall rises only when that queue is full.
//   Reset empties the queue and the response register and loads the bank:
//   all zero, key input 0x03FF (all keys up), RCNT 0x8000.
// ----------------------------------------------------------------------------
module keypad_serial_register_block #(
    parameter int unsigned QUEUE_DEPTH = kpsr_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  kpsr_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output kpsr_pkg::rsp_t  rsp
);

    kpsr_pkg::cmd_t push_cmd;
    kpsr_pkg::cmd_t head_cmd;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_not_empty;

    kpsr_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    kpsr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    kpsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- test/tb_keypad_serial_register_block.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_serial_register_block: self-checking bench for the keypad window
// Drives bus reads, bus writes and key events through the request channel,
// predicts every response from a private copy of the register bank and checks
// the responses in order. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_keypad_serial_register_block;

    localparam int ITEMS          = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_AT       = 400;
    localparam int HOLD_AT        = 700;
    localparam int HOLD_CYCLES    = 80;
    localparam int CALM_ITEMS     = 250;

    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_ODD  = 2'd3;   // decoded as a word

    localparam int KEYIN_HW  = 8;
    localparam int KEYCTL_HW = 9;
    localparam int RCNT_HW   = 10;

    localparam logic [7:0] ADDR_KEYIN  = 8'h10;
    localparam logic [7:0] ADDR_KEYCTL = 8'h12;
    localparam logic [7:0] ADDR_RCNT   = 8'h14;
    localparam logic [7:0] WINDOW_END  = 8'h3C;

    localparam logic [3:0] KEY_A   = 4'd0;
    localparam logic [3:0] KEY_B   = 4'd1;
    localparam logic [3:0] KEY_L   = 4'd9;
    localparam logic [3:0] KEY_BAD = 4'd15;

    localparam logic [15:0] CTL_EN  = 16'h1 << kpsr_pkg::IRQ_EN_BIT;
    localparam logic [15:0] CTL_AND = 16'h1 << kpsr_pkg::IRQ_AND_BIT;

    // halfword offsets that read as zero, and those backed by the bank
    localparam logic [7:0][7:0] ZERO_HW_OFFS = {
        8'h00, 8'h02, 8'h04, 8'h06, 8'h16, 8'h30, 8'h32, 8'h38
    };
    localparam logic [7:0][7:0] BANK_HW_OFFS = {
        8'h08, 8'h0A, 8'h10, 8'h12, 8'h14, 8'h20, 8'h34, 8'h36
    };

    class keypad_window_tracker;
        logic [15:0]      regs [30];
        kpsr_pkg::rsp_t   window_responses [$];
        int               errors;
        int               n_read, n_miss, n_write, n_key, n_irq, n_none;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            regs[KEYIN_HW] = kpsr_pkg::KEY_RESET;
            regs[RCNT_HW]  = kpsr_pkg::RCNT_RESET;
            errors = 0;
            n_read = 0; n_miss = 0; n_write = 0; n_key = 0; n_irq = 0; n_none = 0;
        endfunction

        function bit read_half(input logic [7:0] addr, output logic [15:0] val);
            logic [7:0] a;
            a   = {addr[7:1], 1'b0};
            val = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (a == BANK_HW_OFFS[i])
                begin
                    val = regs[a[5:1]];
                    return 1'b1;
                end
                if (a == ZERO_HW_OFFS[i])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void write_half(input logic [7:0] addr, input logic [15:0] val);
            logic [7:0] a;
            a = {addr[7:1], 1'b0};
            if (a >= WINDOW_END || a == ADDR_KEYIN)
                return;
            regs[a[5:1]] = val;
        endfunction

        function void write_byte(input logic [7:0] addr, input logic [7:0] val);
            if (addr >= WINDOW_END || addr[7:1] == ADDR_KEYIN[7:1])
                return;
            if (addr[0])
                regs[addr[5:1]][15:8] = val;
            else
                regs[addr[5:1]][7:0] = val;
        endfunction

        function bit key_irq_now();
            logic [15:0]                   ctl;
            logic [kpsr_pkg::KEY_BITS-1:0] pressed, sel;
            ctl     = regs[KEYCTL_HW];
            pressed = ~regs[KEYIN_HW][kpsr_pkg::KEY_BITS-1:0];
            sel     = ctl[kpsr_pkg::KEY_BITS-1:0];
            if (!ctl[kpsr_pkg::IRQ_EN_BIT] || sel == '0 || pressed == '0)
                return 1'b0;
            if (ctl[kpsr_pkg::IRQ_AND_BIT])
                return (pressed & sel) == sel;
            return |(pressed & sel);
        endfunction

        function kpsr_pkg::rsp_t predict_access(input kpsr_pkg::req_t r);
            kpsr_pkg::rsp_t o;
            logic [15:0]    lo, hi, cur, nxt;
            logic [7:0]     a;
            o = '0;
            a = {r.address[7:2], 2'b00};
            case (r.action)
                kpsr_pkg::ACT_READ:
                begin
                    if (r.access_size == kpsr_pkg::SIZE_BYTE)
                    begin
                        if (read_half(r.address, lo))
                        begin
                            o.read_hit  = 1'b1;
                            o.read_data = r.address[0] ? {24'h0, lo[15:8]} : {24'h0, lo[7:0]};
                        end
                    end
                    else if (r.access_size == kpsr_pkg::SIZE_HALF)
                    begin
                        if (read_half(r.address, lo))
                        begin
                            o.read_hit  = 1'b1;
                            o.read_data = {16'h0, lo};
                        end
                    end
                    else if (read_half(a, lo))
                    begin
                        // high half that misses reads as zero
                        o.read_hit = 1'b1;
                        if (!read_half(a + 8'd2, hi))
                            hi = '0;
                        o.read_data = {hi, lo};
                    end
                end
                kpsr_pkg::ACT_WRITE:
                begin
                    o.read_hit = 1'b1;
                    if (r.access_size == kpsr_pkg::SIZE_BYTE)
                        write_byte(r.address, r.write_data[7:0]);
                    else if (r.access_size == kpsr_pkg::SIZE_HALF)
                        write_half(r.address, r.write_data[15:0]);
                    else
                    begin
                        write_half(a, r.write_data[15:0]);
                        write_half(a + 8'd2, r.write_data[31:16]);
                    end
                end
                kpsr_pkg::ACT_KEY:
                begin
                    o.read_hit = 1'b1;
                    if (r.key_number <= kpsr_pkg::KEY_MAX)
                    begin
                        cur = regs[KEYIN_HW];
                        nxt = cur;
                        nxt[r.key_number] = ~r.key_down;
                        if (nxt != cur)
                        begin
                            regs[KEYIN_HW] = nxt;
                            o.key_irq = key_irq_now();
                        end
                    end
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_transfer(input kpsr_pkg::req_t r);
            kpsr_pkg::rsp_t want;
            want = predict_access(r);
            window_responses.push_back(want);
            case (r.action)
                kpsr_pkg::ACT_READ:
                begin
                    n_read++;
                    if (!want.read_hit)
                        n_miss++;
                end
                kpsr_pkg::ACT_WRITE:
                    n_write++;
                kpsr_pkg::ACT_KEY:
                begin
                    n_key++;
                    if (want.key_irq)
                        n_irq++;
                end
                default:
                    n_none++;
            endcase
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_rsp(input kpsr_pkg::rsp_t got);
            kpsr_pkg::rsp_t want;
            if (window_responses.size() == 0)
            begin
                report_mismatch($sformatf("response with nothing pending (data %h hit %b irq %b)",
                                          got.read_data, got.read_hit, got.key_irq));
                return;
            end
            want = window_responses.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
            if (got.read_hit !== want.read_hit)
                report_mismatch($sformatf("read_hit %b, want %b", got.read_hit, want.read_hit));
            if (got.key_irq !== want.key_irq)
                report_mismatch($sformatf("key_irq %b, want %b", got.key_irq, want.key_irq));
        endtask

        task close_out();
            while (window_responses.size() != 0)
            begin
                void'(window_responses.pop_front());
                report_mismatch("response never arrived");
            end
        endtask

        function int outstanding();
            return window_responses.size();
        endfunction
    endclass

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    kpsr_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    kpsr_pkg::rsp_t rsp;

    bit idle_on   = 1'b1;
    int hold_ask  = 0;

    keypad_window_tracker trk = new();

    keypad_serial_register_block DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic kpsr_pkg::req_t mk_req(input logic [1:0] act, input logic [7:0] addr,
                                              input logic [1:0] size, input logic [31:0] data,
                                              input logic [3:0] key, input logic down);
        kpsr_pkg::req_t r;
        r = '{action: act, address: addr, access_size: size, write_data: data,
              key_number: key, key_down: down};
        return r;
    endfunction

    function automatic logic [15:0] rand_key_ctl();
        logic [kpsr_pkg::KEY_BITS-1:0] sel;
        logic [15:0]                   ctl;
        if ($urandom_range(0, 1) == 0)
            sel = kpsr_pkg::KEY_BITS'(1) << $urandom_range(0, kpsr_pkg::KEY_MAX);
        else
            sel = kpsr_pkg::KEY_BITS'($urandom_range(0, (1 << kpsr_pkg::KEY_BITS) - 1));
        ctl = {4'($urandom_range(0, 15)), 2'b00, sel};
        ctl[kpsr_pkg::IRQ_EN_BIT]  = ($urandom_range(0, 7) != 0);
        ctl[kpsr_pkg::IRQ_AND_BIT] = 1'($urandom_range(0, 1));
        return ctl;
    endfunction

    function automatic kpsr_pkg::req_t rand_item();
        kpsr_pkg::req_t r;
        int             pick;
        r.address     = 8'($urandom_range(0, 255));
        r.access_size = 2'($urandom_range(0, 3));
        r.write_data  = $urandom;
        r.key_number  = 4'($urandom_range(0, 15));
        r.key_down    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            r.action = kpsr_pkg::ACT_READ;
            if ($urandom_range(0, 9) < 7)
                r.address = 8'($urandom_range(0, 63));
        end
        else if (pick < 62)
        begin
            r.action = kpsr_pkg::ACT_WRITE;
            if ($urandom_range(0, 9) < 2)
            begin
                r.address          = ADDR_KEYCTL;
                r.access_size      = kpsr_pkg::SIZE_HALF;
                r.write_data[15:0] = rand_key_ctl();
            end
            else if ($urandom_range(0, 9) < 8)
            begin
                r.address = 8'($urandom_range(0, 63));
            end
        end
        else if (pick < 95)
        begin
            r.action = kpsr_pkg::ACT_KEY;
            if ($urandom_range(0, 19) < 18)
                r.key_number = 4'($urandom_range(0, kpsr_pkg::KEY_MAX));
            else
                r.key_number = 4'($urandom_range(kpsr_pkg::KEY_MAX + 1, 15));
        end
        else
        begin
            r.action = kpsr_pkg::ACT_NONE;
        end
        return r;
    endfunction

    task automatic offer(input kpsr_pkg::req_t item);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (trk.outstanding() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall bursts plus one long hold on request
    initial
    begin : receiver
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask > 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                rsp_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 14) - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // transfer monitor and watchdog
    initial
    begin : monitor
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            quiet++;
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                trk.check_rsp(rsp);
                quiet = 0;
            end
            if (rst_n && req_valid && !req_stall)
            begin
                trk.note_transfer(req);
                quiet = 0;
            end
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("keypad_serial_register_block verification failed");
        $finish;
    end

    initial
    begin : stimulus
        kpsr_pkg::req_t directed [$];
        int             sent;
        sent = 0;

        // reset values, then OR and AND interrupt modes, read-only key register
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, ADDR_KEYIN, kpsr_pkg::SIZE_HALF,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, ADDR_RCNT, SIZE_WORD,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, ADDR_RCNT + 8'd1, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_WRITE, ADDR_KEYCTL, kpsr_pkg::SIZE_HALF,
                                  {16'h0, CTL_EN | 16'h0001}, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_B, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_B, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_WRITE, ADDR_KEYCTL, kpsr_pkg::SIZE_HALF,
                                  {16'h0, CTL_EN | CTL_AND | 16'h0003}, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_B, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_B, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_WRITE, ADDR_KEYIN, SIZE_WORD,
                                  32'hC3FF_0000, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_WRITE, ADDR_KEYIN + 8'd1, kpsr_pkg::SIZE_BYTE,
                                  32'h0000_00AA, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_WRITE, ADDR_KEYCTL + 8'd1,
                                  kpsr_pkg::SIZE_BYTE, 32'h0000_0040, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, ADDR_KEYIN, SIZE_ODD,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_WRITE, WINDOW_END, SIZE_WORD,
                                  32'h1234_5678, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_BAD, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_KEY, 8'h0, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_L, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, ADDR_KEYIN + 8'd1, kpsr_pkg::SIZE_BYTE,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_NONE, ADDR_KEYCTL, kpsr_pkg::SIZE_HALF,
                                  32'hFFFF_FFFF, KEY_A, 1'b1));
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, 8'h0C, kpsr_pkg::SIZE_HALF,
                                  32'h0, KEY_A, 1'b0));
        directed.push_back(mk_req(kpsr_pkg::ACT_READ, 8'h35, SIZE_WORD,
                                  32'h0, KEY_A, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            offer(directed[k]);
            sent++;
        end

        while (sent < ITEMS)
        begin
            if (sent == DRAIN_AT)
            begin
                pause_sender(1);
                wait_drained();
            end
            if (sent == HOLD_AT)
                hold_ask = HOLD_CYCLES;
            if (sent == ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            if (idle_on && $urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 14));
            offer(rand_item());
            sent++;
        end

        req_valid <= 1'b0;
        wait_drained();
        repeat (5) @(posedge clk);
        trk.close_out();

        $display("covered %0d reads (%0d misses), %0d writes, %0d key events (%0d irqs), %0d no-ops",
                 trk.n_read, trk.n_miss, trk.n_write, trk.n_key, trk.n_irq, trk.n_none);
        $display("with random stalls on both sides, a long response hold and a full drain");
        if (trk.errors == 0)
            $display("keypad_serial_register_block verification clean");
        else
            $display("keypad_serial_register_block verification failed");
        $finish;
    end

endmodule
